// ----- hw/rtl/humidity_temperature_frame_decoder_macros.svh -----
`ifndef HUMIDITY_TEMPERATURE_FRAME_DECODER_MACROS_SVH
`define HUMIDITY_TEMPERATURE_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HTFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/htfd_pkg.sv -----
package htfd_pkg;

  localparam logic [7:0]  CRC_POLY  = 8'h31;
  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [30:0] T_SPAN    = 31'd17500;
  localparam logic [30:0] H_SPAN    = 31'd12500;
  localparam logic [15:0] T_OFFSET  = 16'd4500;
  localparam logic [15:0] H_OFFSET  = 16'd600;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    POS_T_MSB = 3'd0,
    POS_T_LSB = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_MSB = 3'd3,
    POS_H_LSB = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // Completed frame handed to the conversion pipeline.
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
  } frame_t;

  // Converted result leaving the conversion pipeline.
  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic [14:0] temp_centi;
    logic [14:0] hum_centi;
  } result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535) estimate, low by at most one.
  function automatic logic [14:0] quot_est(input logic [30:0] x);
    logic [31:0] sum;
    sum = 32'(x) + 32'(x[30:16]);
    return sum[30:16];
  endfunction

  // Bump the estimate when (q + 1) * 65535 still fits under x.
  function automatic logic [14:0] quot_fix(input logic [30:0] x, input logic [14:0] q);
    logic [15:0] qp;
    logic [31:0] prod;
    qp   = 16'(q) + 16'd1;
    prod = {qp, 16'h0000} - 32'(qp);
    return (prod <= 32'(x)) ? 15'(qp) : q;
  endfunction

endpackage

// ----- hw/rtl/htfd_in_if.sv -----
interface htfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ----- hw/rtl/htfd_out_if.sv -----
interface htfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] raw_temperature;
  logic [15:0] raw_humidity;
  logic [14:0] temperature_centi;
  logic [14:0] humidity_centi;

  modport source (output valid, output status, output raw_temperature, output raw_humidity,
                  output temperature_centi, output humidity_centi, input ready);
  modport sink   (input valid, input status, input raw_temperature, input raw_humidity,
                  input temperature_centi, input humidity_centi, output ready);
endinterface

// ----- hw/rtl/htfd_convert.sv -----
module htfd_convert (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  htfd_pkg::frame_t frame,
  output htfd_pkg::result_t result
);
  import htfd_pkg::*;

  // stage 1: scale products
  logic        s1_valid_r;
  status_t     s1_status_r;
  logic [15:0] s1_raw_t_r, s1_raw_h_r;
  logic [30:0] s1_xt_r, s1_xh_r;

  // stage 2: quotient estimates
  logic        s2_valid_r;
  status_t     s2_status_r;
  logic [15:0] s2_raw_t_r, s2_raw_h_r;
  logic [30:0] s2_xt_r, s2_xh_r;
  logic [14:0] s2_qt_r, s2_qh_r;

  logic [14:0] qt, qh;
  logic [15:0] t_full, h_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= frame.valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_status_r <= frame.status;
      s1_raw_t_r  <= frame.raw_t;
      s1_raw_h_r  <= frame.raw_h;
      s1_xt_r     <= 31'(frame.raw_t) * T_SPAN;
      s1_xh_r     <= 31'(frame.raw_h) * H_SPAN;
      s2_status_r <= s1_status_r;
      s2_raw_t_r  <= s1_raw_t_r;
      s2_raw_h_r  <= s1_raw_h_r;
      s2_xt_r     <= s1_xt_r;
      s2_xh_r     <= s1_xh_r;
      s2_qt_r     <= quot_est(s1_xt_r);
      s2_qh_r     <= quot_est(s1_xh_r);
    end
  end

  always_comb begin
    qt     = quot_fix(s2_xt_r, s2_qt_r);
    qh     = quot_fix(s2_xh_r, s2_qh_r);
    t_full = 16'(qt) - T_OFFSET;
    h_full = 16'(qh) - H_OFFSET;
    result.valid      = s2_valid_r;
    result.status     = s2_status_r;
    result.raw_t      = s2_raw_t_r;
    result.raw_h      = s2_raw_h_r;
    result.temp_centi = t_full[14:0];
    result.hum_centi  = h_full[14:0];
  end

endmodule

// ----- hw/rtl/humidity_temperature_frame_decoder.sv -----
// A completed frame passes frame_r, stage 1, stage 2 and out_r on its way to out_ch.
// Throughput: one byte per cycle; frame assembly, two conversion stages and the output
//   register all advance together, stalling only while a held result is not taken.
// Reset (rst_n low, synchronous): byte position 0, CRC 0xFF, words and CRC flag cleared,
//   pipeline and output emptied.
module humidity_temperature_frame_decoder (
  input logic        clk,
  input logic        rst_n,
  htfd_in_if.sink    in_ch,
  htfd_out_if.source out_ch
);
  import htfd_pkg::*;

  `include "humidity_temperature_frame_decoder_macros.svh"

  pos_t        pos_r, pos_nxt, pos_cur;
  logic [7:0]  crc_r, crc_nxt, crc_cur;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [15:0] hum_word_r, hum_word_nxt;
  logic        temp_good_r, temp_good_nxt;
  frame_t      frame_r, frame_nxt;
  result_t     conv;
  result_t     out_r;
  logic        en, acc, restart, hum_good;

  assign en           = !out_r.valid || out_ch.ready;
  assign acc          = in_ch.valid && en;
  assign in_ch.ready  = en;

  always_comb begin
    restart       = in_ch.frame_start || (pos_r > POS_H_CRC);
    pos_cur       = restart ? POS_T_MSB : pos_r;
    crc_cur       = restart ? CRC_INIT : crc_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    temp_word_nxt = temp_word_r;
    hum_word_nxt  = hum_word_r;
    temp_good_nxt = temp_good_r;
    hum_good      = (crc_cur == in_ch.rx_byte);
    frame_nxt.valid  = 1'b0;
    frame_nxt.raw_t  = temp_word_r;
    frame_nxt.raw_h  = hum_word_r;
    frame_nxt.status = !temp_good_r ? STATUS_TEMP_CRC :
                       (!hum_good ? STATUS_HUM_CRC : STATUS_OK);
    if (acc) begin
      unique case (pos_cur)
        POS_T_MSB: begin
          temp_word_nxt = {in_ch.rx_byte, 8'h00};
          crc_nxt       = crc8_byte(CRC_INIT, in_ch.rx_byte);
          pos_nxt       = POS_T_LSB;
        end
        POS_T_LSB: begin
          temp_word_nxt = {temp_word_r[15:8], in_ch.rx_byte};
          crc_nxt       = crc8_byte(crc_cur, in_ch.rx_byte);
          pos_nxt       = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_good_nxt = (crc_cur == in_ch.rx_byte);
          crc_nxt       = CRC_INIT;
          pos_nxt       = POS_H_MSB;
        end
        POS_H_MSB: begin
          hum_word_nxt = {in_ch.rx_byte, 8'h00};
          crc_nxt      = crc8_byte(CRC_INIT, in_ch.rx_byte);
          pos_nxt      = POS_H_LSB;
        end
        POS_H_LSB: begin
          hum_word_nxt = {hum_word_r[15:8], in_ch.rx_byte};
          crc_nxt      = crc8_byte(crc_cur, in_ch.rx_byte);
          pos_nxt      = POS_H_CRC;
        end
        default: begin
          crc_nxt         = CRC_INIT;
          pos_nxt         = POS_T_MSB;
          frame_nxt.valid = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_MSB;
      crc_r       <= CRC_INIT;
      temp_word_r <= '0;
      hum_word_r  <= '0;
      temp_good_r <= 1'b0;
      frame_r     <= '0;
      out_r       <= '0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      hum_word_r  <= hum_word_nxt;
      temp_good_r <= temp_good_nxt;
      if (en) begin
        frame_r <= frame_nxt;
        out_r   <= conv;
      end
    end
  end

  htfd_convert u_convert (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .frame  (frame_r),
    .result (conv)
  );

  assign out_ch.valid             = out_r.valid;
  assign out_ch.status            = out_r.status;
  assign out_ch.raw_temperature   = out_r.raw_t;
  assign out_ch.raw_humidity      = out_r.raw_h;
  assign out_ch.temperature_centi = out_r.temp_centi;
  assign out_ch.humidity_centi    = out_r.hum_centi;

  `HTFD_ASSERT_NEXT(a_frame_on_sixth, acc && pos_cur == POS_H_CRC, frame_r.valid, "frame lost")
  `HTFD_ASSERT_NEXT(a_crc_reload, acc && pos_cur == POS_T_CRC, crc_r == CRC_INIT, "crc kept")
  `HTFD_ASSERT_NEXT(a_stall_pos, !en, pos_r == $past(pos_r), "position moved in stall")
  `HTFD_ASSERT_NEXT(a_stall_crc, !en, crc_r == $past(crc_r), "crc moved in stall")
  `HTFD_ASSERT_NOW(a_status_code, out_r.valid, out_r.status <= STATUS_HUM_CRC, "bad status")

endmodule

// ----- verif/humidity_temperature_frame_decoder_tb.sv -----
module humidity_temperature_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htfd_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_BYTES_PER_PHASE = 232;

  typedef struct {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_item_t;

  typedef struct {
    status_t     status;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
    logic [14:0] temp_centi;
    logic [14:0] hum_centi;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  htfd_in_if  in_ch ();
  htfd_out_if out_ch ();

  humidity_temperature_frame_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  rx_item_t rx_bytes_q[$];
  reading_t readings_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  bit in_taken = 1'b0;
  bit need_start = 1'b1;

  // predictor state
  logic [2:0]  frame_pos = POS_T_MSB;
  logic [7:0]  crc_acc = CRC_INIT;
  logic [15:0] temp_word = '0;
  logic [15:0] hum_word = '0;
  logic        temp_crc_ok = 1'b0;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    acc = crc ^ data;
    repeat (8) begin
      if (acc[7]) acc = {acc[6:0], 1'b0} ^ CRC_POLY;
      else acc = {acc[6:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [14:0] to_centi(input logic [15:0] raw, input int unsigned span,
                                           input int unsigned offset);
    int unsigned q;
    q = (span * raw) / 32'd65535;
    return 15'(q - offset);
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output reading_t rd);
    logic [2:0] pos;
    logic       hum_crc_ok;
    rd = '{STATUS_OK, '0, '0, '0, '0};
    if (start || frame_pos > POS_H_CRC) begin
      frame_pos = POS_T_MSB;
      crc_acc = CRC_INIT;
    end
    pos = frame_pos;
    frame_pos = 3'(pos + 3'd1);
    case (pos)
      POS_T_MSB: begin
        temp_word = {b, 8'h00};
        crc_acc = crc8_step(CRC_INIT, b);
      end
      POS_T_LSB: begin
        temp_word[7:0] = b;
        crc_acc = crc8_step(crc_acc, b);
      end
      POS_T_CRC: begin
        temp_crc_ok = (crc_acc == b);
        crc_acc = CRC_INIT;
      end
      POS_H_MSB: begin
        hum_word = {b, 8'h00};
        crc_acc = crc8_step(CRC_INIT, b);
      end
      POS_H_LSB: begin
        hum_word[7:0] = b;
        crc_acc = crc8_step(crc_acc, b);
      end
      default: begin
        hum_crc_ok = (crc_acc == b);
        crc_acc = CRC_INIT;
        frame_pos = POS_T_MSB;
        if (!temp_crc_ok) rd.status = STATUS_TEMP_CRC;
        else if (!hum_crc_ok) rd.status = STATUS_HUM_CRC;
        else rd.status = STATUS_OK;
        rd.raw_t = temp_word;
        rd.raw_h = hum_word;
        rd.temp_centi = to_centi(temp_word, 17500, 4500);
        rd.hum_centi = to_centi(hum_word, 12500, 600);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic start);
    rx_bytes_q.push_back('{b, start});
    bytes_queued++;
  endtask

  task automatic push_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input bit t_ok, input bit h_ok, input bit with_start);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = crc8_step(crc8_step(CRC_INIT, t_raw[15:8]), t_raw[7:0]);
    h_crc = crc8_step(crc8_step(CRC_INIT, h_raw[15:8]), h_raw[7:0]);
    if (!t_ok) t_crc = t_crc ^ 8'($urandom_range(255, 1));
    if (!h_ok) h_crc = h_crc ^ 8'($urandom_range(255, 1));
    push_byte(t_raw[15:8], with_start || need_start);
    push_byte(t_raw[7:0], 1'b0);
    push_byte(t_crc, 1'b0);
    push_byte(h_raw[15:8], 1'b0);
    push_byte(h_raw[7:0], 1'b0);
    push_byte(h_crc, 1'b0);
    need_start = 1'b0;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_random(input int count);
    int first;
    int kind;
    int len;
    first = bytes_queued;
    while (bytes_queued - first < count) begin
      kind = $urandom_range(99);
      if (kind < 82) begin
        push_frame(pick_word(), pick_word(), $urandom_range(9) != 0,
                   $urandom_range(9) != 0, 1'($urandom_range(1)));
      end else if (kind < 92) begin
        // truncated frame, dropped by the next start
        len = $urandom_range(5, 1);
        push_byte(8'($urandom), 1'b1);
        for (int i = 1; i < len; i++) push_byte(8'($urandom), 1'b0);
        need_start = 1'b1;
      end else begin
        push_byte(8'($urandom), 1'($urandom_range(1)));
        need_start = 1'b1;
      end
    end
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || readings_due.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    rx_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = rx_bytes_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= nxt.rx_byte;
        in_ch.frame_start <= nxt.frame_start;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    bit out_xfer;
    bit in_xfer;
    out_xfer = rst_n && out_ch.valid && out_ch.ready;
    in_xfer = rst_n && in_ch.valid && in_ch.ready;
    in_taken <= in_xfer;
    if (out_xfer) begin
      got = '{status_t'(out_ch.status), out_ch.raw_temperature, out_ch.raw_humidity,
              out_ch.temperature_centi, out_ch.humidity_centi};
      if (readings_due.size() == 0) begin
        $error("unexpected reading: status %0d raw_temperature %0d raw_humidity %0d",
               got.status, got.raw_t, got.raw_h);
        fail_count++;
      end else begin
        want = readings_due.pop_front();
        check_field("status", want.status, got.status);
        check_field("raw_temperature", want.raw_t, got.raw_t);
        check_field("raw_humidity", want.raw_h, got.raw_h);
        check_field("temperature_centi", $signed(want.temp_centi), $signed(got.temp_centi));
        check_field("humidity_centi", $signed(want.hum_centi), $signed(got.hum_centi));
      end
    end
    if (in_xfer) begin
      bytes_taken++;
      if (decode_byte(in_ch.rx_byte, in_ch.frame_start, want)) readings_due.push_back(want);
    end
    quiet_cycles = (in_xfer || out_xfer) ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int stall_phase[4][2];
    stall_phase = '{'{0, 0}, '{60, 0}, '{0, 60}, '{14, 14}};
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // scale extremes, wrap without start, aborted frame, both CRC error kinds
    push_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
    push_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    push_byte(8'hA5, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_frame(16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b1);
    push_frame(16'h6666, 16'hEDCB, 1'b1, 1'b0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      send_idle_pct = stall_phase[ph][0];
      recv_stall_pct = stall_phase[ph][1];
      push_random(RANDOM_BYTES_PER_PHASE);
      // sender holds until every reading of this phase is out
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_in_if.sv
hw/rtl/htfd_out_if.sv
hw/rtl/htfd_convert.sv
hw/rtl/humidity_temperature_frame_decoder.sv
verif/humidity_temperature_frame_decoder_tb.sv
